@@ hw/rtl/sac_pkg.sv @@
package sac_pkg;

   // request function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   localparam logic [4:0] CMD_PREFIX   = 5'h18;
   localparam logic [9:0] ANALOG_MASK  = 10'h3FF;
   localparam logic [9:0] DIGITAL_MASK = 10'h001;
   localparam logic [7:0] MAX_CHANNEL  = 8'd8;
   localparam logic [5:0] CMD_TICKS    = 6'd10;
   localparam logic [5:0] LAST_TICK    = 6'd34;

   typedef struct packed {
      logic       func;
      logic [7:0] channel;
      logic       digital_mode;
      logic       miso;
   } req_type;

   typedef struct packed {
      logic       chip_select_n;
      logic       serial_clock;
      logic       serial_out;
      logic       busy_res;
      logic       done_res;
      logic [9:0] sample_value;
   } rsp_type;

endpackage

@@ hw/rtl/sac_chan_if.sv @@
interface sac_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] channel;
   logic       digital_mode;
   logic       miso;

   modport source (output valid, func, channel, digital_mode, miso, input ready);
   modport sink   (input valid, func, channel, digital_mode, miso, output ready);
endinterface

interface sac_rsp_if;
   logic       valid;
   logic       ready;
   logic       chip_select_n;
   logic       serial_clock;
   logic       serial_out;
   logic       busy_res;
   logic       done_res;
   logic [9:0] sample_value;

   modport source (output valid, chip_select_n, serial_clock, serial_out, busy_res,
                   done_res, sample_value, input ready);
   modport sink   (input valid, chip_select_n, serial_clock, serial_out, busy_res,
                   done_res, sample_value, output ready);
endinterface

@@ hw/rtl/sac_seq.sv @@
module sac_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  sac_pkg::req_type req,
   output sac_pkg::rsp_type rsp
);

   logic        active_ff, active_in;
   logic [5:0]  idx_ff, idx_in;
   logic [4:0]  cmd_ff, cmd_in;
   logic [11:0] rx_ff, rx_in;
   logic        mode_ff, mode_in;
   logic        dout_ff, dout_in;
   logic        done;
   logic [9:0]  value;

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      cmd_in    = cmd_ff;
      rx_in     = rx_ff;
      mode_in   = mode_ff;
      dout_in   = dout_ff;
      done      = 1'b0;
      value     = '0;
      if (req.func == sac_pkg::FUNC_START) begin
         if (!active_ff) begin
            if (req.channel > sac_pkg::MAX_CHANNEL) begin
               done = 1'b1;
            end else begin
               active_in = 1'b1;
               idx_in    = '0;
               // channel 8 folds onto the prefix bit, same command as channel 0
               cmd_in    = sac_pkg::CMD_PREFIX | req.channel[4:0];
               rx_in     = '0;
               mode_in   = req.digital_mode;
            end
         end
      end else if (active_ff) begin
         if (idx_ff >= sac_pkg::LAST_TICK) begin
            active_in = 1'b0;
            idx_in    = '0;
            done      = 1'b1;
            value     = rx_ff[9:0] & (mode_ff ? sac_pkg::DIGITAL_MASK : sac_pkg::ANALOG_MASK);
         end else begin
            // even half-periods raise SCK: drive MOSI or sample MISO
            if (!idx_ff[0]) begin
               if (idx_ff < sac_pkg::CMD_TICKS) begin
                  dout_in = cmd_ff[4];
                  cmd_in  = {cmd_ff[3:0], 1'b0};
               end else begin
                  rx_in = {rx_ff[10:0], req.miso};
               end
            end
            idx_in = idx_ff + 6'd1;
         end
      end
   end

   always_comb begin
      rsp.chip_select_n = !active_in;
      rsp.serial_clock  = active_in && idx_in[0];
      rsp.serial_out    = dout_in;
      rsp.busy_res      = active_in;
      rsp.done_res      = done;
      rsp.sample_value  = value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
         dout_ff   <= 1'b0;
      end else if (fire) begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         dout_ff   <= dout_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         cmd_ff  <= cmd_in;
         rx_ff   <= rx_in;
         mode_ff <= mode_in;
      end
   end

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= sac_pkg::LAST_TICK)
      else $error("half-period index past last tick");

   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> idx_ff == 6'd0)
      else $error("index nonzero while idle");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.done_res |=> !active_ff)
      else $error("still active after done");

   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      fire && req.func == sac_pkg::FUNC_START && active_ff |=> active_ff && $stable(idx_ff))
      else $error("start while busy disturbed the sequence");
`endif

endmodule

@@ hw/rtl/sac_out_stage.sv @@
module sac_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  sac_pkg::rsp_type data,
   output logic             can_load,
   sac_rsp_if.source        rsp_bus
);

   logic             valid_ff, valid_in;
   sac_pkg::rsp_type data_ff;

   assign can_load = !valid_ff || rsp_bus.ready;
   assign valid_in = load || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.chip_select_n = data_ff.chip_select_n;
   assign rsp_bus.serial_clock  = data_ff.serial_clock;
   assign rsp_bus.serial_out    = data_ff.serial_out;
   assign rsp_bus.busy_res      = data_ff.busy_res;
   assign rsp_bus.done_res      = data_ff.done_res;
   assign rsp_bus.sample_value  = data_ff.sample_value;

endmodule

@@ hw/rtl/spi_adc_channel_reader.sv @@
// SPI master for an 8-channel converter, driven one request at a time. A start
// request (func 0) with channel 0..8 drops chip select and latches the command
// {1,1,channel[2:0]}; a channel above 8 returns done at once with value 0, and a
// start while busy is ignored. Each tick request (func 1) is one SCK half-period:
// 10 ticks shift the command out MSB first, 24 ticks sample 12 MISO bits on the
// rising SCK phase, and one more tick raises chip select and returns done with
// the low 10 bits (bit 0 only in digital mode). Every request gives exactly one
// response carrying the pin levels after it. One request per clock is taken
// unless the response side stalls: a request is held in the input register
// until the response register can load, then the sequencer state and the
// response register update together on the same edge.
module spi_adc_channel_reader (
   input  logic      clock,
   input  logic      reset,
   sac_req_if.sink   req_bus,
   sac_rsp_if.source rsp_bus
);

   logic             in_valid_ff, in_valid_in;
   sac_pkg::req_type in_req_ff;
   sac_pkg::rsp_type step_rsp;
   logic             out_free;
   logic             advance;
   logic             accept;

   assign advance       = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;
   assign in_valid_in   = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff.func         <= req_bus.func;
         in_req_ff.channel      <= req_bus.channel;
         in_req_ff.digital_mode <= req_bus.digital_mode;
         in_req_ff.miso         <= req_bus.miso;
      end
   end

   sac_seq u_seq (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_req_ff),
      .rsp   (step_rsp)
   );

   sac_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .data     (step_rsp),
      .can_load (out_free),
      .rsp_bus  (rsp_bus)
   );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int QUIET_LIMIT = 2000;
   localparam int REQUEST_TARGET = 1250;
   localparam int CALM_TAIL = 200;
   localparam int CONV_TICKS = 35;

   logic clock = 1'b0;
   logic reset;

   sac_req_if req_bus ();
   sac_rsp_if rsp_bus ();

   spi_adc_channel_reader uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #4 clock = ~clock;

   // shadow of the converter sequencer
   logic       adc_active;
   logic [5:0] adc_half;
   logic [4:0] adc_command;
   logic [11:0] adc_received;
   logic       adc_digital;
   logic       adc_mosi;

   sac_pkg::rsp_type pins_expected[$];

   bit idle_on;
   int requests_sent;
   int conversions_done;
   int immediate_zeros;
   int ignored_starts;
   int mismatches;
   int quiet_cycles;
   int stall_left;

   function automatic sac_pkg::rsp_type predict_pins(input sac_pkg::req_type r);
      sac_pkg::rsp_type o;
      logic       done;
      logic [9:0] value;
      int         pos;
      done = 1'b0;
      value = '0;
      if (r.func == sac_pkg::FUNC_START) begin
         if (adc_active) begin
            ignored_starts++;
         end else if (r.channel > sac_pkg::MAX_CHANNEL) begin
            done = 1'b1;
            immediate_zeros++;
         end else begin
            adc_active = 1'b1;
            adc_half = '0;
            // channel 8 folds onto channel 0's command
            adc_command = sac_pkg::CMD_PREFIX | r.channel[4:0];
            adc_received = '0;
            adc_digital = r.digital_mode;
         end
      end else if (adc_active) begin
         if (adc_half >= sac_pkg::LAST_TICK) begin
            value = adc_received[9:0] &
                    (adc_digital ? sac_pkg::DIGITAL_MASK : sac_pkg::ANALOG_MASK);
            adc_active = 1'b0;
            adc_half = '0;
            done = 1'b1;
            conversions_done++;
         end else begin
            if (adc_half < sac_pkg::CMD_TICKS) begin
               if (!adc_half[0]) begin
                  pos = 4 - int'(adc_half >> 1);
                  adc_mosi = adc_command[pos];
               end
            end else if (!adc_half[0]) begin
               // sampled on the half-period that raises SCK
               pos = 11 - int'((adc_half - sac_pkg::CMD_TICKS) >> 1);
               adc_received[pos] = adc_received[pos] | r.miso;
            end
            adc_half = adc_half + 6'd1;
         end
      end
      o.chip_select_n = ~adc_active;
      o.serial_clock = adc_active & adc_half[0];
      o.serial_out = adc_mosi;
      o.busy_res = adc_active;
      o.done_res = done;
      o.sample_value = value;
      return o;
   endfunction

   task automatic send_request(input logic func, input logic [7:0] channel,
                               input logic dmode, input logic miso);
      sac_pkg::req_type r;
      r = '{func: func, channel: channel, digital_mode: dmode, miso: miso};
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= r.func;
      req_bus.channel <= r.channel;
      req_bus.digital_mode <= r.digital_mode;
      req_bus.miso <= r.miso;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pins_expected.push_back(predict_pins(r));
      requests_sent++;
   endtask

   // start, then every half-period through the closing tick; MISO carries
   // sample_bits on the sampling ticks and noise elsewhere
   task automatic convert_channel(input logic [7:0] channel, input logic dmode,
                                  input logic [11:0] sample_bits, input int busy_start_at);
      int   i;
      logic miso;
      send_request(sac_pkg::FUNC_START, channel, dmode, 1'($urandom));
      for (i = 0; i < CONV_TICKS; i++) begin
         if (i == busy_start_at)
            send_request(sac_pkg::FUNC_START, 8'($urandom), 1'($urandom), 1'($urandom));
         miso = 1'($urandom);
         if (i >= sac_pkg::CMD_TICKS && i < sac_pkg::LAST_TICK &&
             ((i - sac_pkg::CMD_TICKS) % 2) == 0)
            miso = sample_bits[11 - (i - sac_pkg::CMD_TICKS) / 2];
         send_request(sac_pkg::FUNC_TICK, 8'($urandom), 1'($urandom), miso);
      end
   endtask

   task automatic test_idle_requests;
      send_request(sac_pkg::FUNC_START, 8'd9, 1'b0, 1'b0);
      send_request(sac_pkg::FUNC_START, 8'd255, 1'b1, 1'b1);
      send_request(sac_pkg::FUNC_START, 8'h76, 1'b0, 1'b1);
      send_request(sac_pkg::FUNC_TICK, 8'd0, 1'b1, 1'b1);
      send_request(sac_pkg::FUNC_TICK, 8'd255, 1'b0, 1'b0);
   endtask

   task automatic test_directed_conversions;
      convert_channel(8'd7, 1'b0, 12'hFFF, -1);
      convert_channel(8'd8, 1'b1, 12'hFFF, 6);
      convert_channel(8'd0, 1'b0, 12'h000, -1);
   endtask

   task automatic test_random_traffic;
      int pick;
      int n;
      while (requests_sent < REQUEST_TARGET) begin
         idle_on = (requests_sent < REQUEST_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            convert_channel(8'($urandom_range(0, 8)), 1'($urandom), 12'($urandom),
                            ($urandom_range(0, 4) == 0) ? $urandom_range(0, CONV_TICKS - 1) : -1);
            repeat ($urandom_range(0, 2))
               send_request(sac_pkg::FUNC_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
         end else if (pick == 8) begin
            send_request(sac_pkg::FUNC_START, 8'($urandom_range(9, 255)), 1'($urandom),
                         1'($urandom));
         end else begin
            n = $urandom_range(1, 5);
            repeat (n) send_request(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
         end
      end
   endtask

   // response side: random stall bursts while idling is on
   always @(posedge clock) begin
      if (!idle_on) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(1, 7) - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sac_pkg::rsp_type got;
      sac_pkg::rsp_type want;
      string   bad;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.chip_select_n = rsp_bus.chip_select_n;
         got.serial_clock = rsp_bus.serial_clock;
         got.serial_out = rsp_bus.serial_out;
         got.busy_res = rsp_bus.busy_res;
         got.done_res = rsp_bus.done_res;
         got.sample_value = rsp_bus.sample_value;
         if (pins_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with no request outstanding: %p", $realtime, got);
         end else begin
            want = pins_expected.pop_front();
            bad = "";
            if (got.chip_select_n !== want.chip_select_n) bad = {bad, " chip_select_n"};
            if (got.serial_clock !== want.serial_clock) bad = {bad, " serial_clock"};
            if (got.serial_out !== want.serial_out) bad = {bad, " serial_out"};
            if (got.busy_res !== want.busy_res) bad = {bad, " busy_res"};
            if (got.done_res !== want.done_res) bad = {bad, " done_res"};
            if (got.sample_value !== want.sample_value) bad = {bad, " sample_value"};
            if (bad != "") begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch in%s\n   expected %p\n   actual   %p",
                           $realtime, bad, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no traffic for %0d cycles, %0d responses outstanding",
                  QUIET_LIMIT, pins_expected.size());
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      idle_on = 1'b1;
      stall_left = 0;
      quiet_cycles = 0;
      req_bus.valid = 1'b0;
      req_bus.func = sac_pkg::FUNC_START;
      req_bus.channel = '0;
      req_bus.digital_mode = 1'b0;
      req_bus.miso = 1'b0;
      rsp_bus.ready = 1'b0;
      adc_active = 1'b0;
      adc_half = '0;
      adc_command = '0;
      adc_received = '0;
      adc_digital = 1'b0;
      adc_mosi = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_requests();
      test_directed_conversions();
      test_random_traffic();

      req_bus.valid <= 1'b0;
      while (pins_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d requests: %0d conversions read back, %0d bad-channel starts",
               requests_sent, conversions_done, immediate_zeros);
      $display("%0d starts ignored while busy, %0d mismatches", ignored_starts, mismatches);
      if (mismatches == 0 && pins_expected.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

@@ spi_adc_channel_reader.f @@
hw/rtl/sac_pkg.sv
hw/rtl/sac_chan_if.sv
hw/rtl/sac_seq.sv
hw/rtl/sac_out_stage.sv
hw/rtl/spi_adc_channel_reader.sv
tb/testbench.sv
